// ===== src/i3d_pkg.sv =====
`timescale 1ns / 1ps
// i3d_pkg: shared constants, types and helper functions of the 3d distance block
// no dependencies

package i3d_pkg;

    localparam int COORD_BITS = 32;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int SCALE_W    = 5;
    localparam int ROOT_STEPS = WORD_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int IN_W       = 6 * WORD_W;

    localparam logic [WORD_W-1:0] ROOT_BIT_INIT = 32'h4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic square;
        logic sum;
        logic root_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic out_full;
    } status_t;

    // difference wrapped to COORD_BITS and sign extended to a full word
    function automatic logic [WORD_W-1:0] diff_wrap(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0]            d;
        logic signed [COORD_BITS-1:0] t;
        d = a - b;
        t = d[COORD_BITS-1:0];
        return WORD_W'(t);
    endfunction

    // true when the word fits a signed half word
    function automatic logic fits_half(input logic [WORD_W-1:0] v);
        return (&v[WORD_W-1:HALF_W-1]) | ~(|v[WORD_W-1:HALF_W-1]);
    endfunction

    // magnitude of a value that fits a signed half word
    function automatic logic [HALF_W-1:0] mag_half(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] n;
        n = WORD_W'(0) - v;
        return v[WORD_W-1] ? n[HALF_W-1:0] : v[HALF_W-1:0];
    endfunction

endpackage

// ===== src/i3d_ctrl.sv =====
`timescale 1ns / 1ps
// i3d_ctrl: controller state machine of the 3d distance block
// depends on i3d_pkg

module i3d_ctrl import i3d_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t                state_reg, state_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (status.fits) begin
                    state_next = ST_SQUARE;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/i3d_datapath.sv =====
`timescale 1ns / 1ps
// i3d_datapath: differences, scaling shifter, squares, restoring root, output register
// depends on i3d_pkg

module i3d_datapath import i3d_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IN_W-1:0]   s_tdata,
    input  cmd_t              cmd,
    output status_t           status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata
);

    logic [WORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [WORD_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [WORD_W-1:0]  n_reg, root_reg, bit_reg;
    logic [WORD_W-1:0]  m_tdata_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [HALF_W-1:0]  mx, my, mz;
    logic [WORD_W-1:0]  trial;

    assign mx    = mag_half(x_reg);
    assign my    = mag_half(y_reg);
    assign mz    = mag_half(z_reg);
    assign trial = bit_reg + root_reg;

    assign status.fits     = fits_half(x_reg) & fits_half(y_reg) & fits_half(z_reg);
    assign status.out_full = m_tvalid_reg & ~m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= diff_wrap(s_tdata[0*WORD_W +: WORD_W], s_tdata[3*WORD_W +: WORD_W]);
            y_reg     <= diff_wrap(s_tdata[1*WORD_W +: WORD_W], s_tdata[4*WORD_W +: WORD_W]);
            z_reg     <= diff_wrap(s_tdata[2*WORD_W +: WORD_W], s_tdata[5*WORD_W +: WORD_W]);
            scale_reg <= '0;
        end else if (cmd.shift) begin
            x_reg     <= {x_reg[WORD_W-1], x_reg[WORD_W-1:1]};
            y_reg     <= {y_reg[WORD_W-1], y_reg[WORD_W-1:1]};
            z_reg     <= {z_reg[WORD_W-1], z_reg[WORD_W-1:1]};
            scale_reg <= scale_reg + 1'b1;
        end
        if (cmd.square) begin
            sqx_reg <= WORD_W'(mx) * WORD_W'(mx);
            sqy_reg <= WORD_W'(my) * WORD_W'(my);
            sqz_reg <= WORD_W'(mz) * WORD_W'(mz);
        end
        if (cmd.sum) begin
            n_reg    <= sqx_reg + sqy_reg + sqz_reg;
            root_reg <= '0;
            bit_reg  <= ROOT_BIT_INIT;
        end else if (cmd.root_step) begin
            if (trial <= n_reg) begin
                n_reg    <= n_reg - trial;
                root_reg <= (root_reg >> 1) | bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.emit) begin
            m_tdata_reg <= root_reg << scale_reg;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/integer_3d_distance.sv =====
`timescale 1ns / 1ps
// integer_3d_distance: top level of the integer 3d distance block
// depends on i3d_pkg, i3d_ctrl, i3d_datapath
//
//  channel | dir | tdata fields, lowest bits first
//  s_      | in  | first_x, first_y, first_z, second_x, second_y, second_z (32 each)
//  m_      | out | distance (32, unsigned)
//
// a request runs through the one-bit-a-step scaling shifter for 0..16 scaling shifts,
// then through the squares, the sum and the 16-step restoring root loop
// one request in flight; the next one is taken while the result waits in the output reg
// a stalled result holds the block in its last state until m_tready
// synchronous active-low reset clears the controller and m_tvalid

module integer_3d_distance import i3d_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // first_x, first_y, first_z, second_x, second_y, second_z
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata    // distance
);

    cmd_t    cmd;
    status_t status;

    i3d_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i3d_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/i3d_checker.sv =====
`timescale 1ns / 1ps
// i3d_checker: port-level assertions for integer_3d_distance, bound to the top level
// depends on i3d_pkg

module i3d_checker import i3d_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [WORD_W-1:0] m_tdata
);

    // a stalled result stays valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no result right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // reset clears the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind integer_3d_distance i3d_checker u_i3d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
